### rtl/dual_port_branch_target_buffer_core_assert.svh
// assertion macros for the branch target buffer
`ifndef DUAL_PORT_BRANCH_TARGET_BUFFER_CORE_ASSERT_SVH
`define DUAL_PORT_BRANCH_TARGET_BUFFER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define DPBTB_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("dpbtb: invariant violated");

// consequent holds in the same cycle as the antecedent
`define DPBTB_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpbtb: implication violated");

`endif

### rtl/dpbtb_pkg.sv
`default_nettype none

package dpbtb_pkg;

   localparam int unsigned EntriesDefault = 16;
   localparam int unsigned AddrWidth      = 32;
   localparam int unsigned WordWidth      = 30;

   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [WordWidth-1:0] word_type;

   // one beat travelling down the row of entries
   typedef struct packed {
      logic     valid;
      word_type look_a;
      word_type look_b;
      logic     hit_a;
      word_type tgt_a;
      logic     hit_b;
      word_type tgt_b;
      logic     pend_a;
      word_type wb_key_a;
      word_type wb_val_a;
      logic     pend_b;
      word_type wb_key_b;
      word_type wb_val_b;
   } token_type;

   function automatic word_type to_word(addr_type addr);
      return addr[AddrWidth-1:AddrWidth-WordWidth];
   endfunction

endpackage

`default_nettype wire

### rtl/dpbtb_cell.sv
`default_nettype none

module dpbtb_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire dpbtb_pkg::token_type tok_in,
   output dpbtb_pkg::token_type      tok_out,
   output logic                     used
);
   import dpbtb_pkg::*;

   logic      used_ff;
   logic      used_in;
   word_type  branch_ff;
   word_type  branch_in;
   word_type  target_ff;
   word_type  target_in;
   token_type tok_ff;
   token_type tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      used_in     = used_ff;
      branch_in   = branch_ff;
      target_in   = target_ff;
      if (tok_in.valid) begin
         // lookups see the entry as it was before this beat's commits
         if (!tok_in.hit_a && used_ff && (branch_ff == tok_in.look_a)) begin
            tok_in_next.hit_a = 1'b1;
            tok_in_next.tgt_a = target_ff;
         end
         if (!tok_in.hit_b && used_ff && (branch_ff == tok_in.look_b)) begin
            tok_in_next.hit_b = 1'b1;
            tok_in_next.tgt_b = target_ff;
         end
         // used entries form a prefix, so the first free cell is past every match
         if (tok_in.pend_a) begin
            if (used_in && (branch_in == tok_in.wb_key_a)) begin
               target_in          = tok_in.wb_val_a;
               tok_in_next.pend_a = 1'b0;
            end else if (!used_in) begin
               used_in            = 1'b1;
               branch_in          = tok_in.wb_key_a;
               target_in          = tok_in.wb_val_a;
               tok_in_next.pend_a = 1'b0;
            end
         end
         if (tok_in.pend_b) begin
            if (used_in && (branch_in == tok_in.wb_key_b)) begin
               target_in          = tok_in.wb_val_b;
               tok_in_next.pend_b = 1'b0;
            end else if (!used_in) begin
               used_in            = 1'b1;
               branch_in          = tok_in.wb_key_b;
               target_in          = tok_in.wb_val_b;
               tok_in_next.pend_b = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         used_ff <= used_in;
         tok_ff  <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         branch_ff <= branch_in;
         target_ff <= target_in;
      end
   end

   assign tok_out = tok_ff;
   assign used    = used_ff;

endmodule

`default_nettype wire

### rtl/dual_port_branch_target_buffer_core.sv
// channel   direction  payload
// req       in         lookup_pc_a/b, wb_valid_a/b, wb_pc_a/b, wb_target_a/b
// rsp       out        hit_a, target_a, hit_b, target_b
//
// a beat walks the row of ENTRIES cells, one cell register after another, then lands in
// the output register, one beat per cycle unless the row is frozen.
// the per-cell hop is what sets latency; throughput is one beat a cycle unless frozen.
// reset clears all used bits and the pipeline valids.
// the row freezes only while a beat sits in the last cell and the
// output register is held by rsp_stall.
`default_nettype none

`include "dual_port_branch_target_buffer_core_assert.svh"

module dual_port_branch_target_buffer_core #(
   parameter int unsigned ENTRIES = dpbtb_pkg::EntriesDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire dpbtb_pkg::addr_type req_lookup_pc_a,
   input  wire dpbtb_pkg::addr_type req_lookup_pc_b,
   input  wire logic                req_wb_valid_a,
   input  wire dpbtb_pkg::addr_type req_wb_pc_a,
   input  wire dpbtb_pkg::addr_type req_wb_target_a,
   input  wire logic                req_wb_valid_b,
   input  wire dpbtb_pkg::addr_type req_wb_pc_b,
   input  wire dpbtb_pkg::addr_type req_wb_target_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_hit_a,
   output dpbtb_pkg::addr_type      rsp_target_a,
   output logic                     rsp_hit_b,
   output dpbtb_pkg::addr_type      rsp_target_b
);
   import dpbtb_pkg::*;

   token_type          chain [ENTRIES+1];
   token_type          head;
   token_type          last;
   logic [ENTRIES-1:0] used_vec;
   logic [ENTRIES-1:0] used_inc;
   logic               advance;
   logic               rsp_valid_ff;
   logic               hit_a_ff;
   logic               hit_b_ff;
   word_type           word_a_ff;
   word_type           word_b_ff;
   word_type           key_a;
   word_type           key_b;
   word_type           wkey_a;
   word_type           wkey_b;

   assign last    = chain[ENTRIES];
   assign advance = !(last.valid && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign key_a  = to_word(req_lookup_pc_a);
   assign key_b  = to_word(req_lookup_pc_b);
   assign wkey_a = to_word(req_wb_pc_a);
   assign wkey_b = to_word(req_wb_pc_b);

   // writeback bypass is settled up front; cells only fill in misses
   always_comb begin
      head          = '0;
      head.valid    = req_valid;
      head.look_a   = key_a;
      head.look_b   = key_b;
      head.pend_a   = req_wb_valid_a;
      head.wb_key_a = wkey_a;
      head.wb_val_a = to_word(req_wb_target_a);
      head.pend_b   = req_wb_valid_b;
      head.wb_key_b = wkey_b;
      head.wb_val_b = to_word(req_wb_target_b);
      if (req_wb_valid_a && (wkey_a == key_a)) begin
         head.hit_a = 1'b1;
         head.tgt_a = head.wb_val_a;
      end else if (req_wb_valid_b && (wkey_b == key_a)) begin
         head.hit_a = 1'b1;
         head.tgt_a = head.wb_val_b;
      end
      if (req_wb_valid_a && (wkey_a == key_b)) begin
         head.hit_b = 1'b1;
         head.tgt_b = head.wb_val_a;
      end else if (req_wb_valid_b && (wkey_b == key_b)) begin
         head.hit_b = 1'b1;
         head.tgt_b = head.wb_val_b;
      end
   end

   assign chain[0] = head;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      dpbtb_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (chain[i]),
         .tok_out (chain[i+1]),
         .used    (used_vec[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && last.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last.valid) begin
         hit_a_ff  <= last.hit_a;
         hit_b_ff  <= last.hit_b;
         word_a_ff <= last.tgt_a;
         word_b_ff <= last.tgt_b;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit_a    = hit_a_ff;
   assign rsp_hit_b    = hit_b_ff;
   assign rsp_target_a = {word_a_ff, 2'b00};
   assign rsp_target_b = {word_b_ff, 2'b00};

   assign used_inc = used_vec + 1'b1;

   // used slots always form a prefix starting at cell zero
   `DPBTB_ASSERT_ALWAYS(a_used_prefix, (used_vec & used_inc) == '0)
   // a filled slot is never released
   `DPBTB_ASSERT_IMPLY(a_used_sticky, !$past(reset), (used_vec & $past(used_vec)) == $past(used_vec))
   // a miss reports a zero target
   `DPBTB_ASSERT_IMPLY(a_miss_zero, rsp_valid_ff && !hit_a_ff, word_a_ff == '0)

endmodule

`default_nettype wire
